// ===== rtl/assert_macros.svh =====
// assertion macros shared by the station table rtl
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define STT_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define STT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/stt_pkg.sv =====
// types, codes and helpers for the station statistics table
// no dependencies
`default_nettype none
package stt_pkg;

	localparam logic [1:0] CMD_UPDATE = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_INDEX  = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	localparam logic [2:0] OP_UPDATE = 3'd0;
	localparam logic [2:0] OP_ZERO   = 3'd1;
	localparam logic [2:0] OP_LOOKUP = 3'd2;
	localparam logic [2:0] OP_INDEX  = 3'd3;
	localparam logic [2:0] OP_CLEAR  = 3'd4;

	localparam logic [2:0] STS_NEW       = 3'd0;
	localparam logic [2:0] STS_UPDATED   = 3'd1;
	localparam logic [2:0] STS_FULL      = 3'd2;
	localparam logic [2:0] STS_IGNORED   = 3'd3;
	localparam logic [2:0] STS_FOUND     = 3'd4;
	localparam logic [2:0] STS_NOT_FOUND = 3'd5;
	localparam logic [2:0] STS_CLEARED   = 3'd6;

	localparam logic [15:0] PKT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [31:0]        station_id;
		logic [3:0]         protocol_code;
		logic signed [11:0] rssi;
		logic [7:0]         slot_index;
		logic [31:0]        now_ms;
	} stt_req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [7:0]         res_slot;
		logic [31:0]        res_station;
		logic [3:0]         res_protocol;
		logic [15:0]        res_packets;
		logic signed [11:0] res_mean_rssi;
		logic signed [11:0] res_best_rssi;
		logic [31:0]        res_first_ms;
		logic [31:0]        res_last_ms;
		logic               res_active;
		logic [7:0]         res_count;
	} stt_rsp_t;

	typedef struct packed {
		logic [2:0] op;
		stt_req_t   req;
	} stt_op_t;

	typedef struct packed {
		logic [31:0]        id;
		logic [3:0]         proto;
		logic [15:0]        pkt;
		logic signed [11:0] mean;
		logic signed [11:0] best;
		logic [31:0]        first;
		logic [31:0]        last;
	} stt_entry_t;

	function automatic stt_rsp_t stt_make_rsp(input logic [2:0] status, input logic has,
			input logic [7:0] slot, input stt_entry_t e, input logic [7:0] count);
		stt_rsp_t r;
		r = '0;
		r.status = status;
		if (has) begin
			r.res_slot      = slot;
			r.res_station   = e.id;
			r.res_protocol  = e.proto;
			r.res_packets   = e.pkt;
			r.res_mean_rssi = e.mean;
			r.res_best_rssi = e.best;
			r.res_first_ms  = e.first;
			r.res_last_ms   = e.last;
			r.res_active    = 1'b1;
		end
		r.res_count = count;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/stt_front.sv =====
// front end: accepts items, classifies the command, two-entry queue to the back end
// depends on stt_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module stt_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire stt_pkg::stt_req_t req,
	input  wire logic             req_valid,
	output logic                  req_ready,
	output stt_pkg::stt_op_t      q,
	output logic                  q_valid,
	input  wire logic             q_ready
);
	import stt_pkg::*;

	stt_op_t    buf_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	stt_op_t    cls;

	always_comb begin
		cls.req = req;
		case (req.cmd)
			CMD_UPDATE: cls.op = (req.station_id == 32'd0) ? OP_ZERO : OP_UPDATE;
			CMD_LOOKUP: cls.op = OP_LOOKUP;
			CMD_INDEX:  cls.op = OP_INDEX;
			default:    cls.op = OP_CLEAR;
		endcase
	end

	assign req_ready = (cnt_q != 2'd2);
	assign q_valid   = (cnt_q != 2'd0);
	assign q         = buf_q[rd_q];
	assign push      = req_valid && req_ready;
	assign pop       = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= cls;
	end

	`STT_ASSERT(a_cnt_range, cnt_q <= 2'd2, "queue count out of range")
	`STT_IMPLY(a_no_push_full, push, cnt_q != 2'd2, "push into full queue")
	`STT_IMPLY(a_ptrs_when_empty, cnt_q == 2'd0, wr_q == rd_q, "queue pointers disagree")
endmodule
`default_nettype wire

// ===== rtl/stt_back.sv =====
// back end: entry memory, linear id search, running-mean divider, result register
// depends on stt_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module stt_back #(
	parameter int ENTRIES = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire stt_pkg::stt_op_t q,
	input  wire logic             q_valid,
	output logic                  q_ready,
	output stt_pkg::stt_rsp_t     rsp,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready
);
	import stt_pkg::*;

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_CMP  = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_DSET = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_WR   = 3'd6;

	stt_entry_t mem [ENTRIES];
	stt_entry_t rd_q;
	logic [2:0] state_q;
	stt_op_t    op_q;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] occ_q;
	logic          hit_q;
	logic [15:0]   n_q;
	logic signed [29:0] prod_q;
	logic          neg_q;
	logic [15:0]   rem_q;
	logic [28:0]   quo_q;
	logic [4:0]    dcnt_q;
	stt_rsp_t      rsp_q;
	logic          rsp_valid_q;

	logic          take;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	stt_entry_t    wr_data;
	stt_entry_t    upd;
	stt_entry_t    fresh;
	logic [11:0]   qmean;
	logic [16:0]   shifted;
	logic [15:0]   n_next;

	assign q_ready   = (state_q == S_IDLE) && !rsp_valid_q;
	assign take      = q_valid && q_ready;
	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	assign qmean   = neg_q ? (12'd0 - quo_q[11:0]) : quo_q[11:0];
	assign shifted = {rem_q, quo_q[28]};
	assign n_next  = (rd_q.pkt != PKT_MAX) ? (rd_q.pkt + 16'd1) : PKT_MAX;

	always_comb begin
		upd      = rd_q;
		upd.pkt  = n_q;
		upd.mean = $signed(qmean);
		upd.best = (op_q.req.rssi > rd_q.best) ? op_q.req.rssi : rd_q.best;
		upd.last = op_q.req.now_ms;
		fresh.id    = op_q.req.station_id;
		fresh.proto = op_q.req.protocol_code;
		fresh.pkt   = 16'd1;
		fresh.mean  = op_q.req.rssi;
		fresh.best  = op_q.req.rssi;
		fresh.first = op_q.req.now_ms;
		fresh.last  = op_q.req.now_ms;
		wr_en   = (state_q == S_WR);
		wr_addr = hit_q ? ptr_q[AW-1:0] : occ_q[AW-1:0];
		wr_data = hit_q ? upd : fresh;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[ptr_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= '0;
			ptr_q       <= '0;
			occ_q       <= '0;
			hit_q       <= 1'b0;
			n_q         <= '0;
			prod_q      <= '0;
			neg_q       <= 1'b0;
			rem_q       <= '0;
			quo_q       <= '0;
			dcnt_q      <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (take) begin
						op_q  <= q;
						ptr_q <= '0;
						case (q.op)
							OP_ZERO: begin
								rsp_q <= stt_make_rsp(STS_IGNORED, 1'b0, 8'd0, rd_q, 8'(occ_q));
								rsp_valid_q <= 1'b1;
							end
							OP_CLEAR: begin
								occ_q <= '0;
								rsp_q <= stt_make_rsp(STS_CLEARED, 1'b0, 8'd0, rd_q, 8'd0);
								rsp_valid_q <= 1'b1;
							end
							OP_INDEX: begin
								if (q.req.slot_index < 8'(occ_q)) begin
									ptr_q   <= CW'(q.req.slot_index);
									state_q <= S_RD;
								end else begin
									rsp_q <= stt_make_rsp(STS_NOT_FOUND, 1'b0, 8'd0, rd_q,
										8'(occ_q));
									rsp_valid_q <= 1'b1;
								end
							end
							default: begin
								// lookup or update
								if (occ_q != '0) begin
									state_q <= S_RD;
								end else if (q.op == OP_UPDATE) begin
									hit_q   <= 1'b0;
									state_q <= S_WR;
								end else begin
									rsp_q <= stt_make_rsp(STS_NOT_FOUND, 1'b0, 8'd0, rd_q,
										8'(occ_q));
									rsp_valid_q <= 1'b1;
								end
							end
						endcase
					end
				end
				S_RD: state_q <= S_CMP;
				S_CMP: begin
					if (op_q.op == OP_INDEX || rd_q.id == op_q.req.station_id) begin
						if (op_q.op == OP_UPDATE) begin
							hit_q   <= 1'b1;
							state_q <= S_MUL;
						end else begin
							rsp_q <= stt_make_rsp(STS_FOUND, 1'b1, 8'(ptr_q), rd_q, 8'(occ_q));
							rsp_valid_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end else if (ptr_q + CW'(1) == occ_q) begin
						if (op_q.op != OP_UPDATE) begin
							rsp_q <= stt_make_rsp(STS_NOT_FOUND, 1'b0, 8'd0, rd_q, 8'(occ_q));
							rsp_valid_q <= 1'b1;
							state_q <= S_IDLE;
						end else if (occ_q == FULL_CNT) begin
							rsp_q <= stt_make_rsp(STS_FULL, 1'b0, 8'd0, rd_q, 8'(occ_q));
							rsp_valid_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							hit_q   <= 1'b0;
							state_q <= S_WR;
						end
					end else begin
						ptr_q   <= ptr_q + CW'(1);
						state_q <= S_RD;
					end
				end
				S_MUL: begin
					// mean*(n-1) + rssi, n-1 is the old count unless saturated
					n_q    <= n_next;
					prod_q <= 30'($signed(rd_q.mean)) * 30'($signed({1'b0, n_next - 16'd1}))
						+ 30'(op_q.req.rssi);
					state_q <= S_DSET;
				end
				S_DSET: begin
					neg_q   <= prod_q[29];
					quo_q   <= prod_q[29] ? 29'(-prod_q) : prod_q[28:0];
					rem_q   <= '0;
					dcnt_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					// restoring divide, one quotient bit per cycle
					if (shifted >= {1'b0, n_q}) begin
						rem_q <= 16'(shifted - {1'b0, n_q});
						quo_q <= {quo_q[27:0], 1'b1};
					end else begin
						rem_q <= shifted[15:0];
						quo_q <= {quo_q[27:0], 1'b0};
					end
					dcnt_q <= dcnt_q + 5'd1;
					if (dcnt_q == 5'd28) state_q <= S_WR;
				end
				S_WR: begin
					if (hit_q) begin
						rsp_q <= stt_make_rsp(STS_UPDATED, 1'b1, 8'(ptr_q), upd, 8'(occ_q));
					end else begin
						occ_q <= occ_q + CW'(1);
						rsp_q <= stt_make_rsp(STS_NEW, 1'b1, 8'(occ_q), fresh,
							8'(occ_q + CW'(1)));
					end
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`STT_ASSERT(a_occ_range, occ_q <= FULL_CNT, "occupancy beyond table size")
	`STT_IMPLY(a_new_grows, $rose(rsp_valid_q) && rsp_q.status == STS_NEW,
		occ_q == $past(occ_q) + CW'(1), "new entry without occupancy step")
	`STT_IMPLY(a_search_in_range, state_q == S_RD || state_q == S_CMP,
		ptr_q < occ_q, "search pointer past occupied entries")
	`STT_IMPLY(a_div_count, state_q == S_DIV, dcnt_q <= 5'd28, "divider ran too long")
endmodule
`default_nettype wire

// ===== rtl/station_stats_table.sv =====
// Station statistics table: up to ENTRIES stations keyed by a nonzero 32-bit id, filled in
// order of first appearance, one result item per request item. Id zero, clear and
// out-of-range reads are answered without a memory read; read by index reads one entry;
// lookup reads and compares the occupied entries in order (the entry memory is read once
// per compared entry); an update of a known station adds the multiply and the 29-step
// serial divider. A two-item queue in front takes new items while the back end works or
// a result waits. No clearing pass after reset.
// depends on stt_pkg, stt_front, stt_back
`default_nettype none
module station_stats_table #(
	parameter int ENTRIES = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire stt_pkg::stt_req_t req,
	input  wire logic              req_valid,
	output logic                   req_ready,
	output stt_pkg::stt_rsp_t      rsp,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready
);
	import stt_pkg::*;

	stt_op_t op;
	logic    op_valid;
	logic    op_ready;

	stt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.q         (op),
		.q_valid   (op_valid),
		.q_ready   (op_ready)
	);

	stt_back #(
		.ENTRIES (ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q         (op),
		.q_valid   (op_valid),
		.q_ready   (op_ready),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready)
	);
endmodule
`default_nettype wire
